>>> hdl/lfps_pkg.sv
// shared types and constants for the line follower pd steering block
package lfps_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_FOLLOW_INTERVAL = 3'd0;
    localparam logic [2:0] REG_FRONT_OFFSET    = 3'd1;
    localparam logic [2:0] REG_FRONT_THRESHOLD = 3'd2;
    localparam logic [2:0] REG_GAIN_P          = 3'd3;
    localparam logic [2:0] REG_GAIN_D          = 3'd4;

    localparam logic [9:0] FRONT_THRESHOLD_RST = 10'd512;
    localparam logic [9:0] GAIN_P_RST          = 10'd100;

    // correction = sum / 100, done as a reciprocal multiply on the magnitude
    localparam int SUM_W      = 24;
    localparam int MAG_W      = 22;
    localparam int QUOT_W     = 15;
    localparam int DIV_MULT_W = 23;
    localparam int DIV_SHIFT  = 29;
    localparam logic [DIV_MULT_W-1:0] DIV_MULT = 23'd5368710;

    typedef enum logic [1:0] {
        ACT_SKIP  = 2'd0,
        ACT_START = 2'd1,
        ACT_STOP  = 2'd2,
        ACT_STEER = 2'd3
    } action_t;

    typedef struct packed {
        logic        mode;
        logic [31:0] now_ms;
        logic [9:0]  front_left_level;
        logic [9:0]  line_left_level;
        logic [9:0]  line_right_level;
        logic [7:0]  start_speed_left;
        logic [7:0]  start_speed_right;
        logic [15:0] slow_after_ms;
        logic [7:0]  slow_speed_left;
        logic [7:0]  slow_speed_right;
    } in_word_t;

endpackage

>>> hdl/lfps_div100.sv
// signed divide by 100 truncating toward zero, as sign and magnitude
module lfps_div100 (
    input  logic signed [lfps_pkg::SUM_W-1:0] sum,
    output logic [lfps_pkg::QUOT_W-1:0]       quot_mag,
    output logic                              quot_neg
);

    logic [lfps_pkg::SUM_W-1:0]                     sum_abs;
    logic [lfps_pkg::MAG_W-1:0]                     mag;
    logic [lfps_pkg::MAG_W+lfps_pkg::DIV_MULT_W-1:0] product;

    assign sum_abs  = sum[lfps_pkg::SUM_W-1] ? (~sum + 1'b1) : sum;
    assign mag      = sum_abs[lfps_pkg::MAG_W-1:0];
    // exact for every magnitude below 2^22
    assign product  = {{lfps_pkg::DIV_MULT_W{1'b0}}, mag}
                    * {{lfps_pkg::MAG_W{1'b0}}, lfps_pkg::DIV_MULT};
    assign quot_mag = product[lfps_pkg::DIV_SHIFT+lfps_pkg::QUOT_W-1:lfps_pkg::DIV_SHIFT];
    assign quot_neg = sum[lfps_pkg::SUM_W-1];

endmodule

>>> hdl/line_follow_pd_steering.sv
// pd line follower steering block, top level
// One word is accepted per clock while in_ready is high, and each produces
// exactly one result word at the output register. The path runs
// input register, decision and gain multiplies, divide by 100, output register;
// run state (timers, base speeds, previous difference, curve flag) is updated
// as a word leaves the input register, so the next word sees it at once. When
// the output word is not taken the stages fill up and in_ready drops only once
// all four registers hold a word.
module line_follow_pd_steering (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               mode,
    input  logic [31:0]        now_ms,
    input  logic [9:0]         front_left_level,
    input  logic [9:0]         line_left_level,
    input  logic [9:0]         line_right_level,
    input  logic [7:0]         start_speed_left,
    input  logic [7:0]         start_speed_right,
    input  logic [15:0]        slow_after_ms,
    input  logic [7:0]         slow_speed_left,
    input  logic [7:0]         slow_speed_right,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         action,
    output logic signed [15:0] drive_left,
    output logic signed [15:0] drive_right,
    output logic signed [10:0] sensor_difference,
    output logic signed [15:0] correction,
    output logic               speed_reduced_now,
    output logic               curve_reached
);

    typedef struct packed {
        lfps_pkg::action_t  act;
        logic [7:0]         base_l;
        logic [7:0]         base_r;
        logic signed [10:0] diff;
        logic signed [21:0] prod_p;
        logic signed [22:0] prod_d;
        logic               reduced;
        logic               curve;
    } prod_word_t;

    typedef struct packed {
        lfps_pkg::action_t           act;
        logic [7:0]                  base_l;
        logic [7:0]                  base_r;
        logic signed [10:0]          diff;
        logic [lfps_pkg::QUOT_W-1:0] quot_mag;
        logic                        quot_neg;
        logic                        reduced;
        logic                        curve;
    } quot_word_t;

    // configuration
    logic [15:0] follow_interval_reg;
    logic [15:0] front_offset_reg;
    logic [9:0]  front_threshold_reg;
    logic [9:0]  gain_p_reg;
    logic [9:0]  gain_d_reg;

    // run state
    logic [31:0]        last_check_reg, last_check_next;
    logic [31:0]        run_start_reg, run_start_next;
    logic [15:0]        pending_slow_reg, pending_slow_next;
    logic [7:0]         slow_left_reg, slow_left_next;
    logic [7:0]         slow_right_reg, slow_right_next;
    logic [7:0]         base_left_reg, base_left_next;
    logic [7:0]         base_right_reg, base_right_next;
    logic signed [10:0] prev_diff_reg, prev_diff_next;
    logic               curve_flag_reg, curve_flag_next;

    // pipeline
    logic                       in_valid_reg;
    lfps_pkg::in_word_t         in_word_reg;
    logic                       p_valid_reg;
    prod_word_t                 p_reg, p_next;
    logic                       q_valid_reg;
    quot_word_t                 q_reg, q_next;
    logic                       out_valid_reg;
    lfps_pkg::action_t          out_act_reg;
    logic signed [15:0]         drive_left_reg, drive_right_reg, corr_reg;
    logic signed [10:0]         diff_reg;
    logic                       reduced_reg, curve_reg;

    logic ready_out, ready_q, ready_p, fire1;

    assign ready_out = !out_valid_reg || out_ready;
    assign ready_q   = !q_valid_reg || ready_out;
    assign ready_p   = !p_valid_reg || ready_q;
    assign in_ready  = !in_valid_reg || ready_p;
    assign fire1     = in_valid_reg && ready_p;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            follow_interval_reg <= '0;
            front_offset_reg    <= '0;
            front_threshold_reg <= lfps_pkg::FRONT_THRESHOLD_RST;
            gain_p_reg          <= lfps_pkg::GAIN_P_RST;
            gain_d_reg          <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                lfps_pkg::REG_FOLLOW_INTERVAL: follow_interval_reg <= cfg_data;
                lfps_pkg::REG_FRONT_OFFSET:    front_offset_reg    <= cfg_data;
                lfps_pkg::REG_FRONT_THRESHOLD: front_threshold_reg <= cfg_data[9:0];
                lfps_pkg::REG_GAIN_P:          gain_p_reg          <= cfg_data[9:0];
                lfps_pkg::REG_GAIN_D:          gain_d_reg          <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            in_word_reg.mode              <= mode;
            in_word_reg.now_ms            <= now_ms;
            in_word_reg.front_left_level  <= front_left_level;
            in_word_reg.line_left_level   <= line_left_level;
            in_word_reg.line_right_level  <= line_right_level;
            in_word_reg.start_speed_left  <= start_speed_left;
            in_word_reg.start_speed_right <= start_speed_right;
            in_word_reg.slow_after_ms     <= slow_after_ms;
            in_word_reg.slow_speed_left   <= slow_speed_left;
            in_word_reg.slow_speed_right  <= slow_speed_right;
        end
    end

    // decision stage
    logic [31:0]        since_check, since_start;
    logic               skip, front_hit, slow_hit;
    logic signed [10:0] diff;
    logic signed [11:0] diff_delta;
    logic signed [21:0] prod_p;
    logic signed [22:0] prod_d;

    assign since_check = in_word_reg.now_ms - last_check_reg;
    assign since_start = in_word_reg.now_ms - run_start_reg;
    assign skip        = (follow_interval_reg != 16'd0)
                      && (since_check <= {16'd0, follow_interval_reg});
    assign front_hit   = ((front_offset_reg == 16'd0) || (since_start > {16'd0, front_offset_reg}))
                      && (in_word_reg.front_left_level < front_threshold_reg);
    assign slow_hit    = (pending_slow_reg != 16'd0) && (since_start > {16'd0, pending_slow_reg});
    assign diff        = $signed({1'b0, in_word_reg.line_left_level})
                       - $signed({1'b0, in_word_reg.line_right_level});
    assign diff_delta  = $signed({diff[10], diff}) - $signed({prev_diff_reg[10], prev_diff_reg});
    assign prod_p      = $signed({1'b0, gain_p_reg}) * diff;
    assign prod_d      = $signed({1'b0, gain_d_reg}) * diff_delta;

    always_comb
    begin
        last_check_next   = last_check_reg;
        run_start_next    = run_start_reg;
        pending_slow_next = pending_slow_reg;
        slow_left_next    = slow_left_reg;
        slow_right_next   = slow_right_reg;
        base_left_next    = base_left_reg;
        base_right_next   = base_right_reg;
        prev_diff_next    = prev_diff_reg;
        curve_flag_next   = curve_flag_reg;

        p_next.act     = lfps_pkg::ACT_SKIP;
        p_next.base_l  = '0;
        p_next.base_r  = '0;
        p_next.diff    = '0;
        p_next.prod_p  = '0;
        p_next.prod_d  = '0;
        p_next.reduced = 1'b0;
        p_next.curve   = curve_flag_reg;

        if (!in_word_reg.mode)
        begin
            curve_flag_next   = 1'b0;
            prev_diff_next    = '0;
            last_check_next   = in_word_reg.now_ms;
            run_start_next    = in_word_reg.now_ms;
            pending_slow_next = in_word_reg.slow_after_ms;
            slow_left_next    = in_word_reg.slow_speed_left;
            slow_right_next   = in_word_reg.slow_speed_right;
            base_left_next    = in_word_reg.start_speed_left;
            base_right_next   = in_word_reg.start_speed_right;
            p_next.act        = lfps_pkg::ACT_START;
            p_next.base_l     = in_word_reg.start_speed_left;
            p_next.base_r     = in_word_reg.start_speed_right;
            p_next.curve      = 1'b0;
        end
        else if (!skip)
        begin
            last_check_next = in_word_reg.now_ms;
            if (front_hit)
            begin
                curve_flag_next = 1'b1;
                p_next.act      = lfps_pkg::ACT_STOP;
                p_next.curve    = 1'b1;
            end
            else
            begin
                // one-time switch to the reduced speeds
                if (slow_hit)
                begin
                    base_left_next    = slow_left_reg;
                    base_right_next   = slow_right_reg;
                    pending_slow_next = '0;
                end
                prev_diff_next = diff;
                p_next.act     = lfps_pkg::ACT_STEER;
                p_next.base_l  = slow_hit ? slow_left_reg : base_left_reg;
                p_next.base_r  = slow_hit ? slow_right_reg : base_right_reg;
                p_next.diff    = diff;
                p_next.prod_p  = prod_p;
                p_next.prod_d  = prod_d;
                p_next.reduced = slow_hit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_check_reg   <= '0;
            run_start_reg    <= '0;
            pending_slow_reg <= '0;
            slow_left_reg    <= '0;
            slow_right_reg   <= '0;
            base_left_reg    <= '0;
            base_right_reg   <= '0;
            prev_diff_reg    <= '0;
            curve_flag_reg   <= 1'b0;
        end
        else if (fire1)
        begin
            last_check_reg   <= last_check_next;
            run_start_reg    <= run_start_next;
            pending_slow_reg <= pending_slow_next;
            slow_left_reg    <= slow_left_next;
            slow_right_reg   <= slow_right_next;
            base_left_reg    <= base_left_next;
            base_right_reg   <= base_right_next;
            prev_diff_reg    <= prev_diff_next;
            curve_flag_reg   <= curve_flag_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_valid_reg <= 1'b0;
        else if (ready_p)
            p_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ready_p)
            p_reg <= p_next;
    end

    // divide stage
    logic signed [lfps_pkg::SUM_W-1:0] pd_sum;
    logic [lfps_pkg::QUOT_W-1:0]       quot_mag;
    logic                              quot_neg;

    assign pd_sum = {{2{p_reg.prod_p[21]}}, p_reg.prod_p} + {p_reg.prod_d[22], p_reg.prod_d};

    lfps_div100 u_div100 (
        .sum      (pd_sum),
        .quot_mag (quot_mag),
        .quot_neg (quot_neg)
    );

    always_comb
    begin
        q_next.act      = p_reg.act;
        q_next.base_l   = p_reg.base_l;
        q_next.base_r   = p_reg.base_r;
        q_next.diff     = p_reg.diff;
        q_next.quot_mag = quot_mag;
        q_next.quot_neg = quot_neg;
        q_next.reduced  = p_reg.reduced;
        q_next.curve    = p_reg.curve;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_valid_reg <= 1'b0;
        else if (ready_q)
            q_valid_reg <= p_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ready_q)
            q_reg <= q_next;
    end

    // output stage
    logic signed [15:0] corr_next;

    assign corr_next = q_reg.quot_neg ? -$signed({1'b0, q_reg.quot_mag})
                                      : $signed({1'b0, q_reg.quot_mag});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ready_out)
            out_valid_reg <= q_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ready_out)
        begin
            out_act_reg     <= q_reg.act;
            drive_left_reg  <= $signed({8'd0, q_reg.base_l}) + corr_next;
            drive_right_reg <= $signed({8'd0, q_reg.base_r}) - corr_next;
            corr_reg        <= corr_next;
            diff_reg        <= q_reg.diff;
            reduced_reg     <= q_reg.reduced;
            curve_reg       <= q_reg.curve;
        end
    end

    assign out_valid         = out_valid_reg;
    assign action            = out_act_reg;
    assign drive_left        = drive_left_reg;
    assign drive_right       = drive_right_reg;
    assign sensor_difference = diff_reg;
    assign correction        = corr_reg;
    assign speed_reduced_now = reduced_reg;
    assign curve_reached     = curve_reg;

endmodule

>>> hdl/lfps_checker.sv
// port-level checks for the line follower steering block, with its bind
module lfps_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic [1:0]         action,
    input logic signed [15:0] drive_left,
    input logic signed [15:0] drive_right,
    input logic signed [10:0] sensor_difference,
    input logic signed [15:0] correction,
    input logic               speed_reduced_now,
    input logic               curve_reached
);

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(action) && $stable(drive_left)
            && $stable(drive_right) && $stable(correction))
    else $error("stalled result word changed");

    // only steering updates carry a difference or a correction
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (action != lfps_pkg::ACT_STEER)
            |-> (correction == 16'sd0) && (sensor_difference == 11'sd0) && !speed_reduced_now)
    else $error("non-steering word with pd fields set");

    // a fast stop halts both motors and raises the curve flag
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (action == lfps_pkg::ACT_STOP)
            |-> curve_reached && (drive_left == 16'sd0) && (drive_right == 16'sd0))
    else $error("fast stop word malformed");

    // a started run clears the curve flag, a skipped sample drives nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((action == lfps_pkg::ACT_START)
            || ((action == lfps_pkg::ACT_SKIP) && (drive_left == 16'sd0)))
            |-> (action == lfps_pkg::ACT_SKIP) ? (drive_right == 16'sd0) : !curve_reached)
    else $error("start or skip word malformed");

endmodule

bind line_follow_pd_steering lfps_checker u_lfps_checker (.*);
